[hdl/morse_letter_blink_encoder_core_assert.svh]
// Assertion macros for the Morse blink encoder.
// Included by the top level; depends on nothing else.
`ifndef MORSE_LETTER_BLINK_ENCODER_CORE_ASSERT_SVH
`define MORSE_LETTER_BLINK_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MLBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define MLBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hdl/mlbe_pkg.sv]
// Shared types, register indexes and the letter table of the Morse blink encoder.
// No dependencies.
package mlbe_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SPACE,
    ST_GAP
  } state_t;

  localparam logic [1:0] REG_DOT  = 2'd0;
  localparam logic [1:0] REG_DASH = 2'd1;
  localparam logic [1:0] REG_EGAP = 2'd2;
  localparam logic [1:0] REG_LGAP = 2'd3;

  localparam logic [7:0] CHAR_A = 8'd65;
  localparam logic [7:0] CHAR_Z = 8'd90;

  typedef struct packed {
    logic [3:0] dot;
    logic [3:0] dash;
    logic [3:0] egap;
    logic [3:0] lgap;
  } cfg_t;

  typedef struct packed {
    logic       level;
    logic [3:0] dur;
    logic       last;
  } seg_t;

  // element count and pattern, first element in bit 3, 1 = dash
  typedef struct packed {
    logic [2:0] cnt;
    logic [3:0] pat;
  } code_t;

  // count in bits 6..4, pattern in 3..0 with first element at bit (count-1)
  localparam logic [6:0] LETTER_CODE [0:25] = '{
    7'h21, 7'h48, 7'h4A, 7'h34, 7'h10, 7'h42, 7'h36, 7'h40, 7'h20,
    7'h47, 7'h35, 7'h44, 7'h23, 7'h22, 7'h37, 7'h46, 7'h4D, 7'h32,
    7'h30, 7'h11, 7'h31, 7'h41, 7'h33, 7'h49, 7'h4B, 7'h4C
  };

  function automatic code_t letter_lookup(input logic [7:0] ch);
    code_t      c;
    logic [6:0] raw;
    logic [7:0] off;
    off   = ch - CHAR_A;
    raw   = LETTER_CODE[off[4:0]];
    c.cnt = raw[6:4];
    case (raw[6:4])
      3'd1:    c.pat = {raw[0], 3'b000};
      3'd2:    c.pat = {raw[1:0], 2'b00};
      3'd3:    c.pat = {raw[2:0], 1'b0};
      3'd4:    c.pat = raw[3:0];
      default: c.pat = 4'd0;
    endcase
    if (ch < CHAR_A || ch > CHAR_Z) begin
      c.cnt = 3'd0;
      c.pat = 4'd0;
    end
    return c;
  endfunction

endpackage

[hdl/mlbe_seq.sv]
// Segment sequencer: walks one letter's elements and emits one segment per step
// into an output register. Depends on mlbe_pkg.
module mlbe_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mlbe_pkg::code_t code,
  input  mlbe_pkg::cfg_t  cfg,
  input  logic            seg_ready,
  output logic            busy,
  output logic            seg_valid,
  output mlbe_pkg::seg_t  seg
);

  mlbe_pkg::state_t state_r, state_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [3:0]       pat_r, pat_nxt;
  logic             valid_r, valid_nxt;
  mlbe_pkg::seg_t   seg_r, seg_nxt;
  logic             slot_free;

  assign slot_free = !valid_r || seg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlbe_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    pat_r <= pat_nxt;
    seg_r <= seg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pat_nxt   = pat_r;
    valid_nxt = valid_r && !seg_ready;
    seg_nxt   = seg_r;
    case (state_r)
      mlbe_pkg::ST_IDLE: begin
        if (start) begin
          cnt_nxt   = code.cnt;
          pat_nxt   = code.pat;
          state_nxt = (code.cnt != 3'd0) ? mlbe_pkg::ST_MARK : mlbe_pkg::ST_GAP;
        end
      end
      mlbe_pkg::ST_MARK: begin
        if (slot_free) begin
          valid_nxt     = 1'b1;
          seg_nxt.level = 1'b0;
          seg_nxt.dur   = pat_r[3] ? cfg.dash : cfg.dot;
          seg_nxt.last  = 1'b0;
          pat_nxt       = {pat_r[2:0], 1'b0};
          state_nxt     = mlbe_pkg::ST_SPACE;
        end
      end
      mlbe_pkg::ST_SPACE: begin
        if (slot_free) begin
          valid_nxt     = 1'b1;
          seg_nxt.level = 1'b1;
          seg_nxt.dur   = cfg.egap;
          seg_nxt.last  = 1'b0;
          cnt_nxt       = cnt_r - 3'd1;
          state_nxt     = (cnt_r == 3'd1) ? mlbe_pkg::ST_GAP : mlbe_pkg::ST_MARK;
        end
      end
      mlbe_pkg::ST_GAP: begin
        if (slot_free) begin
          valid_nxt     = 1'b1;
          seg_nxt.level = 1'b1;
          seg_nxt.dur   = cfg.lgap;
          seg_nxt.last  = 1'b1;
          state_nxt     = mlbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlbe_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != mlbe_pkg::ST_IDLE);
  assign seg_valid = valid_r;
  assign seg       = seg_r;

endmodule

[hdl/morse_letter_blink_encoder_core.sv]
// Morse blink encoder top level: stream ports, APB register file, sequencer.
// Depends on mlbe_pkg, mlbe_seq and morse_letter_blink_encoder_core_assert.svh.
//
// Usage: one ASCII code per input beat on in_tdata. For 'A'..'Z' the block
// returns, per dot or dash, a mark beat (out_tuser 0, dot or dash length) and
// a space beat (out_tuser 1, element gap), then a letter-gap beat with
// out_tlast set. Any other code returns only the letter-gap beat.
// out_tdata carries the duration in time units.
// The single segment sequencer walks a mark and a space state per element,
// then the letter-gap state, emitting one beat per cycle while the output is
// not stalled; the first beat is registered after the sequencer leaves idle.
// in_tready is low while a character is being walked; the next character is
// taken while its predecessor's last beat still waits at the output.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset (synchronous, rst_n low) empties the output and loads the register
// defaults: dot 1, dash 2, element gap 1, letter gap 4.
// Registers at byte addresses 0, 4, 8, 12; write only while idle.
`include "morse_letter_blink_encoder_core_assert.svh"

module morse_letter_blink_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] duration_units, [7:4] zero
  output logic        out_tuser,  // [0] pin_level
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mlbe_pkg::cfg_t  cfg_r, cfg_nxt;
  mlbe_pkg::seg_t  seg;
  logic            busy;
  logic            seg_valid;
  logic            start;
  logic            wr_en;
  logic [3:0]      rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dot: 4'd1, dash: 4'd2, egap: 4'd1, lgap: 4'd4};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        mlbe_pkg::REG_DOT:  cfg_nxt.dot  = pwdata[3:0];
        mlbe_pkg::REG_DASH: cfg_nxt.dash = pwdata[3:0];
        mlbe_pkg::REG_EGAP: cfg_nxt.egap = pwdata[3:0];
        mlbe_pkg::REG_LGAP: cfg_nxt.lgap = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mlbe_pkg::REG_DOT:  rd_val = cfg_r.dot;
      mlbe_pkg::REG_DASH: rd_val = cfg_r.dash;
      mlbe_pkg::REG_EGAP: rd_val = cfg_r.egap;
      mlbe_pkg::REG_LGAP: rd_val = cfg_r.lgap;
      default:            rd_val = 4'd0;
    endcase
  end

  assign prdata = {28'd0, rd_val};

  assign in_tready = !busy;
  assign start     = in_tvalid && in_tready;

  mlbe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .code      (mlbe_pkg::letter_lookup(in_tdata)),
    .cfg       (cfg_r),
    .seg_ready (out_tready),
    .busy      (busy),
    .seg_valid (seg_valid),
    .seg       (seg)
  );

  assign out_tvalid = seg_valid;
  assign out_tdata  = {4'd0, seg.dur};
  assign out_tuser  = seg.level;
  assign out_tlast  = seg.last;

  `MLBE_ASSERT_NEXT(a_one_char_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `MLBE_ASSERT_NOW(a_mark_not_last, clk, rst_n, out_tvalid && !out_tuser, !out_tlast)
  `MLBE_ASSERT_NOW(a_busy_until_gap, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

endmodule

[tb/mlbe_seg_check.sv]
`timescale 1ns / 1ps
// Segment checker for the Morse blink encoder: follows register writes, expands
// each accepted character into its expected segments and compares output beats.
// Depends on mlbe_pkg.
module mlbe_seg_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          segs_pending,
  output int          chars_seen,
  output int          segs_seen
);

  // count in bits 6..4; pattern bit i is element i of the letter, 1 = dash
  localparam logic [6:0] MORSE_TAB [26] = '{
    7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20,
    7'h4E, 7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32,
    7'h30, 7'h11, 7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
  };

  mlbe_pkg::cfg_t timing;
  mlbe_pkg::seg_t segs_due [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  function automatic void push_seg(input logic level, input logic [3:0] dur,
                                   input logic last);
    mlbe_pkg::seg_t s;
    s.level = level;
    s.dur   = dur;
    s.last  = last;
    segs_due.push_back(s);
  endfunction

  function automatic void expand_char(input logic [7:0] ch);
    logic [6:0] ent;
    logic [7:0] off;
    if (ch >= mlbe_pkg::CHAR_A && ch <= mlbe_pkg::CHAR_Z) begin
      off = ch - mlbe_pkg::CHAR_A;
      ent = MORSE_TAB[off[4:0]];
      for (int i = 0; i < ent[6:4]; i++) begin
        push_seg(1'b0, ent[i] ? timing.dash : timing.dot, 1'b0);
        push_seg(1'b1, timing.egap, 1'b0);
      end
    end
    push_seg(1'b1, timing.lgap, 1'b1);
  endfunction

  always @(posedge clk) begin : watch
    mlbe_pkg::seg_t want;
    if (!rst_n) begin
      timing.dot  = 4'd1;
      timing.dash = 4'd2;
      timing.egap = 4'd1;
      timing.lgap = 4'd4;
      segs_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mlbe_pkg::REG_DOT:  timing.dot  = pwdata[3:0];
          mlbe_pkg::REG_DASH: timing.dash = pwdata[3:0];
          mlbe_pkg::REG_EGAP: timing.egap = pwdata[3:0];
          mlbe_pkg::REG_LGAP: timing.lgap = pwdata[3:0];
          default:  ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expand_char(in_tdata);
        chars_seen = chars_seen + 1;
      end
      if (out_tvalid && out_tready) begin
        segs_seen = segs_seen + 1;
        if (segs_due.size() == 0) begin
          report_mismatch("unexpected beat, duration", out_tdata[3:0], 0);
        end else begin
          want = segs_due.pop_front();
          if (out_tuser !== want.level)
            report_mismatch("pin level", out_tuser, want.level);
          if (out_tdata[3:0] !== want.dur)
            report_mismatch("duration", out_tdata[3:0], want.dur);
          if (out_tlast !== want.last)
            report_mismatch("last flag", out_tlast, want.last);
        end
      end
    end
    segs_pending = segs_due.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the Morse blink encoder testbench: clock, reset, character and register
// stimulus, receiver stalls, verdict. Depends on mlbe_pkg, mlbe_seg_check, DUT.
module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int segs_pending;
  int chars_seen;
  int segs_seen;
  bit calm;
  bit hold;
  bit hold_req;

  localparam logic [7:0] DIRECTED [18] = '{
    "A", "Z", "E", "T", "H", "J", "Q", "Y", 8'h00, 8'hFF,
    8'h40, 8'h5B, "a", "z", " ", "9", 8'h80, 8'h7F
  };

  morse_letter_blink_encoder_core dut (.*);

  mlbe_seg_check seg_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fails),
    .segs_pending (segs_pending),
    .chars_seen   (chars_seen),
    .segs_seen    (segs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin : sink
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold) begin
        out_tready = 1'b0;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // long receiver hold-off while characters keep coming
  initial begin : hold_off
    hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold = 1'b1;
    repeat (400) @(posedge clk);
    hold = 1'b0;
  end

  // called and returns at a falling edge
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    logic [7:0] ch;
    repeat (n) begin
      if ($urandom_range(99) < 75) ch = 8'($urandom_range(90, 65));
      else ch = 8'($urandom_range(255));
      send_char(ch);
    end
  endtask

  // drain all outstanding segments, then let the sequencer settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (segs_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom & 32'hFFFF_FFF0) | {28'd0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(input logic [3:0] dot, input logic [3:0] dash,
                            input logic [3:0] egap, input logic [3:0] lgap);
    write_reg(mlbe_pkg::REG_DOT, dot);
    write_reg(mlbe_pkg::REG_DASH, dash);
    write_reg(mlbe_pkg::REG_EGAP, egap);
    write_reg(mlbe_pkg::REG_LGAP, lgap);
  endtask

  initial begin : stim
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = 4'h0;
    pwdata    = 32'h0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_char(DIRECTED[i]);
    drain();

    set_timing(4'd15, 4'd15, 4'd15, 4'd15);
    send_random(35);
    drain();

    // zero-length segments
    set_timing(4'd0, 4'd0, 4'd0, 4'd0);
    send_random(25);
    drain();

    calm = 1'b1;
    set_timing(4'd1, 4'd1, 4'd1, 4'd1);
    send_random(40);
    drain();
    calm = 1'b0;

    set_timing(4'($urandom_range(15)), 4'($urandom_range(15)),
               4'($urandom_range(15)), 4'($urandom_range(15)));
    hold_req = 1'b1;
    send_random(60);
    drain();

    set_timing(4'd3, 4'd9, 4'd2, 4'd7);
    send_random(45);
    drain();

    set_timing(4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)),
               4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)));
    send_random(45);
    drain();

    $display("%0d characters in, %0d segments compared across seven timing settings",
             chars_seen, segs_seen);
    $display("settings included all-zero and all-fifteen, plus a 400-cycle output stall");
    if (fails == 0 && segs_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mlbe_pkg.sv
hdl/mlbe_seq.sv
hdl/morse_letter_blink_encoder_core.sv
tb/mlbe_seg_check.sv
tb/tb_top.sv
